// File: src/vfcm_pkg.sv
// Shared constants, types, face table and address helpers of the voxel mesher.
package vfcm_pkg;

  localparam int SIZE_X = 16;
  localparam int SIZE_Y = 64;
  localparam int SIZE_Z = 16;

  localparam int OP_W   = 2;
  localparam int X_W    = 4;
  localparam int Y_W    = 6;
  localparam int Z_W    = 4;
  localparam int TYPE_W = 8;
  localparam int SIDE_W = 2;
  localparam int VX_W   = 5;
  localparam int VY_W   = 7;
  localparam int VZ_W   = 5;
  localparam int TILE_W = 4;

  localparam int NUM_REGS  = 4;
  localparam int CFG_AW    = 2;
  localparam int NUM_FACES = 6;
  localparam int FACE_VERTS = 6;
  localparam int FACE_IDX_W = 3;

  localparam int BLK_DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int BLK_AW    = $clog2(BLK_DEPTH);
  localparam int YZ_DEPTH  = SIZE_Y * SIZE_Z;
  localparam int XY_DEPTH  = SIZE_X * SIZE_Y;
  localparam int BRD_DEPTH = (YZ_DEPTH > XY_DEPTH) ? YZ_DEPTH : XY_DEPTH;
  localparam int BRD_AW    = $clog2(BRD_DEPTH);
  localparam int BRD_W     = 4;

  localparam logic [TYPE_W-1:0] RESET_TYPE = 8'd6;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_BLOCK  = 2'd0,
    OP_WRITE_BORDER = 2'd1,
    OP_MESH         = 2'd2
  } op_e;

  typedef enum logic [SIDE_W-1:0] {
    SIDE_LEFT  = 2'd0,
    SIDE_RIGHT = 2'd1,
    SIDE_FRONT = 2'd2,
    SIDE_BACK  = 2'd3
  } side_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_LEFT_PRESENT  = 2'd0,
    REG_RIGHT_PRESENT = 2'd1,
    REG_FRONT_PRESENT = 2'd2,
    REG_BACK_PRESENT  = 2'd3
  } reg_idx_e;

  // face order of the exposure mask and of the emitted vertices
  localparam int FACE_LEFT   = 0;
  localparam int FACE_RIGHT  = 1;
  localparam int FACE_FRONT  = 2;
  localparam int FACE_BACK   = 3;
  localparam int FACE_TOP    = 4;
  localparam int FACE_BOTTOM = 5;

  typedef struct packed {
    logic [X_W-1:0]       x;
    logic [Y_W-1:0]       y;
    logic [Z_W-1:0]       z;
    logic [TYPE_W-1:0]    btype;
    logic [NUM_FACES-1:0] exposed;
  } mesh_job_t;

  // corner entry: {dx, dy, dz, u, v}
  localparam logic [4:0] FACE_TAB [NUM_FACES][FACE_VERTS] = '{
    '{5'b00001, 5'b00111, 5'b01000, 5'b01000, 5'b00111, 5'b01110},
    '{5'b10011, 5'b11010, 5'b10101, 5'b11010, 5'b11100, 5'b10101},
    '{5'b00101, 5'b10111, 5'b01100, 5'b01100, 5'b10111, 5'b11110},
    '{5'b00011, 5'b01010, 5'b10001, 5'b01010, 5'b11000, 5'b10001},
    '{5'b01000, 5'b01101, 5'b11010, 5'b11010, 5'b01101, 5'b11111},
    '{5'b00000, 5'b10001, 5'b00110, 5'b10001, 5'b10111, 5'b00110}
  };

  function automatic logic [BLK_AW-1:0] blk_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                                 logic [Z_W-1:0] z);
    int unsigned a;
    a = (32'(x) * SIZE_Y + 32'(y)) * SIZE_Z + 32'(z);
    return a[BLK_AW-1:0];
  endfunction

  function automatic logic [BRD_AW-1:0] yz_addr(logic [Y_W-1:0] y, logic [Z_W-1:0] z);
    int unsigned a;
    a = 32'(y) * SIZE_Z + 32'(z);
    return a[BRD_AW-1:0];
  endfunction

  function automatic logic [BRD_AW-1:0] xy_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
    int unsigned a;
    a = 32'(x) * SIZE_Y + 32'(y);
    return a[BRD_AW-1:0];
  endfunction

endpackage

// File: src/vfcm_ram.sv
// Simple dual-port RAM with per-bit write mask and registered read data.
module vfcm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wmask_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask_i[i]) mem[waddr_i][i] <= wdata_i[i];
      end
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/vfcm_ctrl.sv
// Request sequencer: clearing pass, store writes and neighbor reads for a mesh request.
module vfcm_ctrl import vfcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [X_W-1:0]      cell_x_i,
  input  logic [Y_W-1:0]      cell_y_i,
  input  logic [Z_W-1:0]      cell_z_i,
  input  logic [TYPE_W-1:0]   block_type_i,
  input  logic [SIDE_W-1:0]   border_side_i,
  input  logic [NUM_REGS-1:0] present_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output mesh_job_t           job_o,
  output logic                blk_we_o,
  output logic [BLK_AW-1:0]   blk_waddr_o,
  output logic [TYPE_W-1:0]   blk_wdata_o,
  output logic [BLK_AW-1:0]   blk_raddr_o,
  input  logic [TYPE_W-1:0]   blk_rdata_i,
  output logic                brd_we_o,
  output logic [BRD_AW-1:0]   brd_waddr_o,
  output logic [BRD_W-1:0]    brd_wmask_o,
  output logic [BRD_W-1:0]    brd_wdata_o,
  output logic [BRD_AW-1:0]   brd_raddr_o,
  input  logic [BRD_W-1:0]    brd_rdata_i
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [BLK_AW-1:0]    clr_q;
  logic [2:0]           step_q;
  logic [X_W-1:0]       cx_q;
  logic [Y_W-1:0]       cy_q;
  logic [Z_W-1:0]       cz_q;
  logic [TYPE_W-1:0]    type_q;
  logic [NUM_FACES-1:0] nz_q;
  logic [BRD_W-1:0]     bord_q;

  logic accept, x_ok, y_ok, z_ok, yz_side;
  logic edge_xl, edge_xh, edge_yl, edge_yh, edge_zl, edge_zh;
  logic [X_W-1:0] nx;
  logic [Y_W-1:0] ny;
  logic [Z_W-1:0] nz;
  logic [NUM_FACES-1:0] exposed;
  logic job_pending;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  assign x_ok    = 32'(cell_x_i) < SIZE_X;
  assign y_ok    = 32'(cell_y_i) < SIZE_Y;
  assign z_ok    = 32'(cell_z_i) < SIZE_Z;
  assign yz_side = (side_e'(border_side_i) == SIDE_LEFT) ||
                   (side_e'(border_side_i) == SIDE_RIGHT);

  assign edge_xl = (cx_q == '0);
  assign edge_xh = (32'(cx_q) == SIZE_X - 1);
  assign edge_yl = (cy_q == '0);
  assign edge_yh = (32'(cy_q) == SIZE_Y - 1);
  assign edge_zl = (cz_q == '0);
  assign edge_zh = (32'(cz_q) == SIZE_Z - 1);

  // neighbor address per read step; edges fall back to the center cell
  always_comb begin
    nx = cx_q;
    ny = cy_q;
    nz = cz_q;
    case (step_q)
      3'(FACE_LEFT + 1):   nx = edge_xl ? cx_q : cx_q - 1'b1;
      3'(FACE_RIGHT + 1):  nx = edge_xh ? cx_q : cx_q + 1'b1;
      3'(FACE_FRONT + 1):  nz = edge_zh ? cz_q : cz_q + 1'b1;
      3'(FACE_BACK + 1):   nz = edge_zl ? cz_q : cz_q - 1'b1;
      3'(FACE_TOP + 1):    ny = edge_yh ? cy_q : cy_q + 1'b1;
      3'(FACE_BOTTOM + 1): ny = edge_yl ? cy_q : cy_q - 1'b1;
      default: ;
    endcase
  end

  assign blk_raddr_o = blk_addr(nx, ny, nz);
  assign brd_raddr_o = (step_q == '0) ? yz_addr(cy_q, cz_q) : xy_addr(cx_q, cy_q);

  always_comb begin
    exposed[FACE_LEFT]   = edge_xl ? (!present_i[REG_LEFT_PRESENT] || !bord_q[SIDE_LEFT])
                                   : nz_q[FACE_LEFT];
    exposed[FACE_RIGHT]  = edge_xh ? (!present_i[REG_RIGHT_PRESENT] || !bord_q[SIDE_RIGHT])
                                   : nz_q[FACE_RIGHT];
    exposed[FACE_FRONT]  = edge_zh ? (!present_i[REG_FRONT_PRESENT] || !bord_q[SIDE_FRONT])
                                   : nz_q[FACE_FRONT];
    exposed[FACE_BACK]   = edge_zl ? (!present_i[REG_BACK_PRESENT] || !bord_q[SIDE_BACK])
                                   : nz_q[FACE_BACK];
    exposed[FACE_TOP]    = edge_yh || nz_q[FACE_TOP];
    exposed[FACE_BOTTOM] = edge_yl || nz_q[FACE_BOTTOM];
  end

  assign job_pending = (type_q != '0) && (|exposed);
  assign job_valid_o = (state_q == S_DONE) && job_pending;
  assign job_o       = '{x: cx_q, y: cy_q, z: cz_q, btype: type_q, exposed: exposed};

  // store write port: clearing pass or a write request
  always_comb begin
    blk_we_o    = 1'b0;
    blk_waddr_o = blk_addr(cell_x_i, cell_y_i, cell_z_i);
    blk_wdata_o = block_type_i;
    brd_we_o    = 1'b0;
    brd_waddr_o = yz_side ? yz_addr(cell_y_i, cell_z_i) : xy_addr(cell_x_i, cell_y_i);
    brd_wmask_o = BRD_W'(1) << border_side_i;
    brd_wdata_o = {BRD_W{block_type_i != '0}};
    if (state_q == S_CLEAR) begin
      blk_we_o    = 1'b1;
      blk_waddr_o = clr_q;
      blk_wdata_o = RESET_TYPE;
      brd_we_o    = 32'(clr_q) < BRD_DEPTH;
      brd_waddr_o = clr_q[BRD_AW-1:0];
      brd_wmask_o = '1;
      brd_wdata_o = '1;
    end else if (accept) begin
      case (op_e'(op_i))
        OP_WRITE_BLOCK:  blk_we_o = x_ok && y_ok && z_ok;
        OP_WRITE_BORDER: brd_we_o = yz_side ? (y_ok && z_ok) : (x_ok && y_ok);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (32'(clr_q) == BLK_DEPTH - 1) state_d = S_IDLE;
      S_IDLE: begin
        if (accept && op_e'(op_i) == OP_MESH && x_ok && y_ok && z_ok) state_d = S_READ;
      end
      S_READ:  if (step_q == 3'(NUM_FACES + 1)) state_d = S_DONE;
      S_DONE:  if (!job_pending || job_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_READ) step_q <= step_q + 1'b1;
      else step_q <= '0;
    end
  end

  // read data lands in the cycle after its address step
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q <= cell_x_i;
      cy_q <= cell_y_i;
      cz_q <= cell_z_i;
    end
    if (state_q == S_READ) begin
      if (step_q == 3'd1) begin
        type_q              <= blk_rdata_i;
        bord_q[SIDE_LEFT]   <= brd_rdata_i[SIDE_LEFT];
        bord_q[SIDE_RIGHT]  <= brd_rdata_i[SIDE_RIGHT];
      end
      if (step_q == 3'd2) begin
        bord_q[SIDE_FRONT]  <= brd_rdata_i[SIDE_FRONT];
        bord_q[SIDE_BACK]   <= brd_rdata_i[SIDE_BACK];
      end
      if (step_q >= 3'd2) nz_q[step_q - 3'd2] <= (blk_rdata_i == '0);
    end
  end

endmodule

// File: src/vfcm_emit.sv
// Vertex emitter: walks exposed faces and table corners into the output register.
module vfcm_emit import vfcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  mesh_job_t         job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VX_W-1:0]   vert_x_o,
  output logic [VY_W-1:0]   vert_y_o,
  output logic [VZ_W-1:0]   vert_z_o,
  output logic              tex_u_o,
  output logic              tex_v_o,
  output logic [TILE_W-1:0] tile_col_o,
  output logic [TILE_W-1:0] tile_row_o,
  output logic              last_o
);

  function automatic logic [FACE_IDX_W-1:0] first_set(logic [NUM_FACES-1:0] m);
    logic [FACE_IDX_W-1:0] r;
    r = '0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (m[i]) r = FACE_IDX_W'(i);
    end
    return r;
  endfunction

  logic                  active_q;
  logic [FACE_IDX_W-1:0] face_q;
  logic [2:0]            k_q;
  logic [NUM_FACES-1:0]  mask_q;
  mesh_job_t             job_q;

  logic [NUM_FACES-1:0]  rem;
  logic [4:0]            corner;
  logic                  advance, face_end, last_vert;

  assign job_ready_o = !active_q;
  assign advance     = active_q && (!out_valid_o || out_ready_i);
  assign rem         = mask_q & ~(NUM_FACES'(1) << face_q);
  assign face_end    = (32'(k_q) == FACE_VERTS - 1);
  assign last_vert   = face_end && (rem == '0);
  assign corner      = FACE_TAB[face_q][k_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (advance) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (job_valid_i && !active_q) active_q <= 1'b1;
      else if (advance && last_vert) active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && !active_q) begin
      job_q  <= job_i;
      mask_q <= job_i.exposed;
      face_q <= first_set(job_i.exposed);
      k_q    <= '0;
    end else if (advance) begin
      if (face_end) begin
        k_q    <= '0;
        mask_q <= rem;
        face_q <= first_set(rem);
      end else begin
        k_q <= k_q + 1'b1;
      end
    end
    if (advance) begin
      vert_x_o   <= VX_W'(job_q.x) + VX_W'(corner[4]);
      vert_y_o   <= VY_W'(job_q.y) + VY_W'(corner[3]);
      vert_z_o   <= VZ_W'(job_q.z) + VZ_W'(corner[2]);
      tex_u_o    <= corner[1];
      tex_v_o    <= corner[0];
      tile_col_o <= job_q.btype[TILE_W-1:0];
      tile_row_o <= job_q.btype[TYPE_W-1:TILE_W];
      last_o     <= last_vert;
    end
  end

endmodule

// File: src/voxel_face_culling_mesher_unit.sv
// Top level of the voxel face-culling mesher: config registers, stores, sequencer, emitter.
//
// Input channel (in_valid_i/in_ready_o) takes one request: op 0 writes a block
// type, op 1 writes a neighbor border bit, op 2 meshes one cell. Output channel
// (out_valid_o/out_ready_i) returns one vertex per transfer, last_o on the final
// vertex of a cell. Write requests and meshes of empty or hidden cells return
// nothing. The cfg port sets the four neighbor-present flags; the user must set them
// only while no request is in flight, as the block does not enforce it. A write
// request is written to its store when accepted. A mesh request passes the read
// phase (center plus six neighbors, one address per cycle) and a hand-off state
// before the next request is taken. With the emitter idle, the job moves into the
// emitter's job register and its first vertex into the output register; its 6 to
// 36 vertices then leave at one per cycle while the next request is already being
// processed. After reset a clearing pass writes type 6 into all 16384 store entries
// and sets every border bit, one entry a cycle, with in_ready_o low until it ends.
// When the receiver stalls, the vertex stays in the output register and emission
// pauses; the sequencer holds a finished mesh until the emitter is free.
module voxel_face_culling_mesher_unit import vfcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [X_W-1:0]    cell_x_i,
  input  logic [Y_W-1:0]    cell_y_i,
  input  logic [Z_W-1:0]    cell_z_i,
  input  logic [TYPE_W-1:0] block_type_i,
  input  logic [SIDE_W-1:0] border_side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VX_W-1:0]   vert_x_o,
  output logic [VY_W-1:0]   vert_y_o,
  output logic [VZ_W-1:0]   vert_z_o,
  output logic              tex_u_o,
  output logic              tex_v_o,
  output logic [TILE_W-1:0] tile_col_o,
  output logic [TILE_W-1:0] tile_row_o,
  output logic              last_o
);

  logic [NUM_REGS-1:0] present_q;

  logic              blk_we;
  logic [BLK_AW-1:0] blk_waddr, blk_raddr;
  logic [TYPE_W-1:0] blk_wdata, blk_rdata;
  logic              brd_we;
  logic [BRD_AW-1:0] brd_waddr, brd_raddr;
  logic [BRD_W-1:0]  brd_wmask, brd_wdata, brd_rdata;
  logic              job_valid, job_ready;
  mesh_job_t         job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (cfg_we_i) begin
      present_q[cfg_addr_i] <= cfg_wdata_i;
    end
  end

  vfcm_ram #(
    .DEPTH(BLK_DEPTH),
    .WIDTH(TYPE_W)
  ) u_blk_ram (
    .clk_i  (clk_i),
    .we_i   (blk_we),
    .waddr_i(blk_waddr),
    .wmask_i({TYPE_W{1'b1}}),
    .wdata_i(blk_wdata),
    .raddr_i(blk_raddr),
    .rdata_o(blk_rdata)
  );

  vfcm_ram #(
    .DEPTH(BRD_DEPTH),
    .WIDTH(BRD_W)
  ) u_brd_ram (
    .clk_i  (clk_i),
    .we_i   (brd_we),
    .waddr_i(brd_waddr),
    .wmask_i(brd_wmask),
    .wdata_i(brd_wdata),
    .raddr_i(brd_raddr),
    .rdata_o(brd_rdata)
  );

  vfcm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_z_i     (cell_z_i),
    .block_type_i (block_type_i),
    .border_side_i(border_side_i),
    .present_i    (present_q),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job),
    .blk_we_o     (blk_we),
    .blk_waddr_o  (blk_waddr),
    .blk_wdata_o  (blk_wdata),
    .blk_raddr_o  (blk_raddr),
    .blk_rdata_i  (blk_rdata),
    .brd_we_o     (brd_we),
    .brd_waddr_o  (brd_waddr),
    .brd_wmask_o  (brd_wmask),
    .brd_wdata_o  (brd_wdata),
    .brd_raddr_o  (brd_raddr),
    .brd_rdata_i  (brd_rdata)
  );

  vfcm_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_ready_o(job_ready),
    .job_i      (job),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .vert_x_o   (vert_x_o),
    .vert_y_o   (vert_y_o),
    .vert_z_o   (vert_z_o),
    .tex_u_o    (tex_u_o),
    .tex_v_o    (tex_v_o),
    .tile_col_o (tile_col_o),
    .tile_row_o (tile_row_o),
    .last_o     (last_o)
  );

endmodule

// File: src/vfcm_checker.sv
// Port-level checker for the voxel mesher, bound to the top level.
module vfcm_checker import vfcm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [VX_W-1:0]   vert_x_o,
  input logic [VY_W-1:0]   vert_y_o,
  input logic [VZ_W-1:0]   vert_z_o,
  input logic              tex_u_o,
  input logic              tex_v_o,
  input logic [TILE_W-1:0] tile_col_o,
  input logic [TILE_W-1:0] tile_row_o,
  input logic              last_o
);

  // stalled vertex holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(vert_x_o) &&
      $stable(vert_y_o) && $stable(vert_z_o) && $stable(tex_u_o) && $stable(tex_v_o) &&
      $stable(tile_col_o) && $stable(tile_row_o) && $stable(last_o))
    else $error("output vertex changed while stalled");

  // a cell's vertices leave without gaps when the receiver keeps taking them
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap inside a cell's vertex run");

  // all vertices of one cell carry the same tile
  a_tile_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      tile_col_o == $past(tile_col_o) && tile_row_o == $past(tile_row_o))
    else $error("tile changed within a cell");

  // clearing pass blocks requests right after reset
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("request taken before the clearing pass");

endmodule

bind voxel_face_culling_mesher_unit vfcm_checker u_checker (.*);
